>>> hdl/cigar_reference_window_extract_defines.svh
// Assertion macros for the CIGAR reference window extractor.
// Taken in by the top level only; needs a clock named i_clk and a reset named i_rst_n.
`ifndef CIGAR_REFERENCE_WINDOW_EXTRACT_DEFINES_SVH
`define CIGAR_REFERENCE_WINDOW_EXTRACT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWE_ASSERT_NOW(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_b)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CWE_ASSERT_NEXT(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_b)) else $error(msg);

`endif

>>> hdl/cwe_pkg.sv
// Shared constants, operation codes and helper function for the CIGAR window extractor.
// No dependencies; every module imports it.
package cwe_pkg;

    localparam int OP_LEN_BITS_DEF = 28;
    localparam int CODE_W          = 4;
    localparam int WIN_W           = 31;
    localparam int MID_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF   = 2;

    localparam logic [CODE_W-1:0] CODE_M  = 4'd0;
    localparam logic [CODE_W-1:0] CODE_D  = 4'd2;
    localparam logic [CODE_W-1:0] CODE_EQ = 4'd7;
    localparam logic [CODE_W-1:0] CODE_X  = 4'd8;
    localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

    // True for the M, D, EQ and X operations, which consume reference bases.
    function automatic logic uses_ref(input logic [CODE_W-1:0] code);
        logic hit;
        unique case (code) inside
            CODE_M, CODE_D, CODE_EQ, CODE_X: hit = 1'b1;
            default:                         hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

>>> hdl/cwe_fifo.sv
// Small first-in first-out queue built from flip-flops, one write (unless full) and one read (unless empty) per cycle.
// Depends on cwe_pkg for its default depth, MID_DEPTH_DEF.
module cwe_fifo
    import cwe_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = MID_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_go, rd_go;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

>>> hdl/cwe_front.sv
// Front part: tracks the reference window and trims each operation to the part inside it.
// Depends on cwe_pkg; its records go to the middle queue.
module cwe_front
    import cwe_pkg::*;
#(
    parameter int OP_LEN_BITS = OP_LEN_BITS_DEF,
    localparam int REC_W = OP_LEN_BITS + CODE_W + 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [OP_LEN_BITS-1:0] i_op_len,
    input  logic [CODE_W-1:0]      i_op_code,
    input  logic                   i_first_op,
    input  logic                   i_last_op,
    input  logic [WIN_W-1:0]       i_window_start,
    input  logic [WIN_W-1:0]       i_window_length,
    output logic                   o_rec_valid,
    output logic [REC_W-1:0]       o_rec
);

    localparam int SW = ((OP_LEN_BITS > WIN_W) ? OP_LEN_BITS : WIN_W) + 2;

    // Reference bases still to skip before the window, and still to take inside it.
    logic [WIN_W-1:0]       r_skip_rem, n_skip_rem;
    logic [WIN_W-1:0]       r_take_rem, n_take_rem;
    logic [WIN_W-1:0]       skip, take;
    logic [SW-1:0]          len_x, skip_x, take_x, diff, rest;
    logic                   len_le_skip, take_le_diff;
    logic [OP_LEN_BITS-1:0] use_len;
    logic                   keep;

    always_comb begin
        skip   = i_first_op ? i_window_start  : r_skip_rem;
        take   = i_first_op ? i_window_length : r_take_rem;
        len_x  = SW'(i_op_len);
        skip_x = SW'(skip);
        take_x = SW'(take);
        // The part past the skip region, and what is left of the window after it.
        diff   = len_x - skip_x;
        rest   = take_x + skip_x - len_x;
        len_le_skip  = diff[SW-1] || (diff == '0);
        take_le_diff = rest[SW-1] || (rest == '0);

        n_skip_rem = skip;
        n_take_rem = take;
        use_len    = '0;
        keep       = 1'b0;
        if (take != '0) begin
            if (uses_ref(i_op_code)) begin
                if (len_le_skip) begin
                    n_skip_rem = WIN_W'(skip_x - len_x);
                end else begin
                    n_skip_rem = '0;
                    keep       = 1'b1;
                    if (take_le_diff) begin
                        use_len    = OP_LEN_BITS'(take);
                        n_take_rem = '0;
                    end else begin
                        use_len    = OP_LEN_BITS'(diff);
                        n_take_rem = WIN_W'(rest);
                    end
                end
            end else if (skip == '0) begin
                use_len = i_op_len;
                keep    = (i_op_len != '0);
            end
        end
    end

    assign o_rec_valid = i_accept;
    assign o_rec       = {i_first_op, i_last_op, keep, i_op_code, use_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_rem <= '0;
            r_take_rem <= '0;
        end else if (i_accept) begin
            r_skip_rem <= n_skip_rem;
            r_take_rem <= n_take_rem;
        end
    end

endmodule

>>> hdl/cwe_back.sv
// Back part: merges kept operations of the same code in a one-entry hold and emits results.
// Depends on cwe_pkg; reads the middle queue and writes the result queue.
module cwe_back
    import cwe_pkg::*;
#(
    parameter int OP_LEN_BITS = OP_LEN_BITS_DEF,
    localparam int REC_W = OP_LEN_BITS + CODE_W + 3,
    localparam int RES_W = OP_LEN_BITS + CODE_W + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REC_W-1:0] i_rec,
    input  logic             i_rec_empty,
    output logic             o_rec_pop,
    output logic             o_res_push,
    output logic [RES_W-1:0] o_res,
    input  logic             i_res_full
);

    logic [OP_LEN_BITS-1:0] r_held_len, n_held_len;
    logic [CODE_W-1:0]      r_held_code, n_held_code;
    logic                   r_held_valid, n_held_valid;
    // Set when a record both flushed the hold and closes the CIGAR; the final
    // result then goes out on a later step, with the record still at the head of the middle queue.
    logic                   r_part2, n_part2;

    logic                   step, first, last, keep, hv, same;
    logic [CODE_W-1:0]      code;
    logic [OP_LEN_BITS-1:0] use_len, sat_len;
    logic [OP_LEN_BITS:0]   sum;

    always_comb begin
        {first, last, keep, code, use_len} = i_rec;
        step    = !i_rec_empty && !i_res_full;
        hv      = r_held_valid && !first;
        same    = keep && hv && (code == r_held_code);
        sum     = {1'b0, r_held_len} + {1'b0, use_len};
        sat_len = sum[OP_LEN_BITS] ? '1 : sum[OP_LEN_BITS-1:0];

        n_held_len   = r_held_len;
        n_held_code  = r_held_code;
        n_held_valid = r_held_valid;
        n_part2      = r_part2;
        o_rec_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = {r_held_len, r_held_code, 1'b0, 1'b0};

        if (step) begin
            if (r_part2) begin
                o_res_push   = 1'b1;
                o_res        = {r_held_len, r_held_code, 1'b1, 1'b0};
                o_rec_pop    = 1'b1;
                n_held_valid = 1'b0;
                n_held_len   = '0;
                n_held_code  = CODE_NONE;
                n_part2      = 1'b0;
            end else begin
                n_held_valid = hv;
                if (same) begin
                    n_held_len = sat_len;
                end else if (keep) begin
                    n_held_len   = use_len;
                    n_held_code  = code;
                    n_held_valid = 1'b1;
                end
                if (keep && hv && !same) begin
                    o_res_push = 1'b1;
                    o_res      = {r_held_len, r_held_code, 1'b0, 1'b0};
                    n_part2    = last;
                    o_rec_pop  = !last;
                end else begin
                    o_rec_pop = 1'b1;
                    if (last) begin
                        o_res_push = 1'b1;
                        if (n_held_valid) begin
                            o_res = {n_held_len, n_held_code, 1'b1, 1'b0};
                        end else begin
                            o_res = {{OP_LEN_BITS{1'b0}}, CODE_NONE, 1'b1, 1'b1};
                        end
                        n_held_valid = 1'b0;
                        n_held_len   = '0;
                        n_held_code  = CODE_NONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_len   <= '0;
            r_held_code  <= CODE_NONE;
            r_held_valid <= 1'b0;
            r_part2      <= 1'b0;
        end else begin
            r_held_len   <= n_held_len;
            r_held_code  <= n_held_code;
            r_held_valid <= n_held_valid;
            r_part2      <= n_part2;
        end
    end

endmodule

>>> hdl/cigar_reference_window_extract.sv
// CIGAR reference window extractor, top level.
// A result passes through the middle queue and then the result queue to the result ports.
// Throughput: one transaction per cycle while the middle queue is not full; a transaction
// that both flushes a merged operation and closes its CIGAR stays at the head of the middle
// queue while the back part emits its two results, one per cycle unless the result queue is full.
// Reset is synchronous and active low; it empties both queues and clears all counters.
`include "cigar_reference_window_extract_defines.svh"

module cigar_reference_window_extract
    import cwe_pkg::*;
#(
    parameter int OP_LEN_BITS = OP_LEN_BITS_DEF,
    parameter int MID_DEPTH   = MID_DEPTH_DEF,
    parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Operation input, queue style.
    input  logic                   push,
    output logic                   full,
    input  logic [OP_LEN_BITS-1:0] i_op_len,
    input  logic [CODE_W-1:0]      i_op_code,
    input  logic                   i_first_op,
    input  logic                   i_last_op,
    input  logic [WIN_W-1:0]       i_window_start,
    input  logic [WIN_W-1:0]       i_window_length,
    // Result output, queue style.
    output logic                   empty,
    input  logic                   pop,
    output logic [OP_LEN_BITS-1:0] o_out_len,
    output logic [CODE_W-1:0]      o_out_code,
    output logic                   o_out_last,
    output logic                   o_out_empty
);

    localparam int REC_W = OP_LEN_BITS + CODE_W + 3;
    localparam int RES_W = OP_LEN_BITS + CODE_W + 2;

    // The front part trims every accepted transaction against the window in the
    // same cycle and writes one record into the middle queue. The back part reads
    // that queue, merges operations of equal code and writes finished results
    // into the result queue, whose head drives the result ports. The front part
    // stalls only on a full middle queue, the back part on an empty middle queue or a full result queue.
    logic             accept;
    logic             rec_valid;
    logic [REC_W-1:0] rec_wr, rec_rd;
    logic             mid_full, mid_empty, rec_pop;
    logic             res_push, res_full;
    logic [RES_W-1:0] res_wr, res_rd;

    assign accept = push && !mid_full;
    assign full   = mid_full;

    cwe_front #(
        .OP_LEN_BITS (OP_LEN_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_op_len        (i_op_len),
        .i_op_code       (i_op_code),
        .i_first_op      (i_first_op),
        .i_last_op       (i_last_op),
        .i_window_start  (i_window_start),
        .i_window_length (i_window_length),
        .o_rec_valid     (rec_valid),
        .o_rec           (rec_wr)
    );

    cwe_fifo #(
        .WIDTH (REC_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (rec_valid),
        .i_wr_data (rec_wr),
        .o_full    (mid_full),
        .i_rd_en   (rec_pop),
        .o_rd_data (rec_rd),
        .o_empty   (mid_empty)
    );

    cwe_back #(
        .OP_LEN_BITS (OP_LEN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_rd),
        .i_rec_empty (mid_empty),
        .o_rec_pop   (rec_pop),
        .o_res_push  (res_push),
        .o_res       (res_wr),
        .i_res_full  (res_full)
    );

    cwe_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (res_wr),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (res_rd),
        .o_empty   (empty)
    );

    assign {o_out_len, o_out_code, o_out_last, o_out_empty} = res_rd;

    // An empty-extraction result always closes its CIGAR and carries no operation.
    `CWE_ASSERT_NOW(a_empty_result_form, !empty && o_out_empty, o_out_last && (o_out_len == '0) && (o_out_code == CODE_NONE), "empty-extraction result is malformed")

    // A transaction taken into an empty middle queue cannot have been consumed yet.
    `CWE_ASSERT_NEXT(a_mid_queue_holds, accept && mid_empty, !mid_empty, "record lost in the middle queue")

    // Results only appear when the back part writes one.
    `CWE_ASSERT_NEXT(a_no_invented_result, empty && !res_push, empty, "result appeared without a write")

endmodule
